// ===== sv/circular_deque_assert.svh =====
// ----------------------------------------------------------------------------
// circular_deque_assert.svh
// Assertion macros shared by the deque checker.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("circular_deque: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("circular_deque: assertion failed");

`endif

// ===== sv/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and constants for the circular deque.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int OCC_W     = 5;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_DROP_FRONT = 2'd2,
        REQ_DROP_BACK  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type                 req_type;
        logic signed [WORD_W-1:0]  data_in;
    } t_req_item;

    typedef struct packed {
        t_status                   status;
        logic signed [WORD_W-1:0]  front_word;
        logic signed [WORD_W-1:0]  back_word;
        logic [OCC_W-1:0]          occupancy;
        logic                      is_empty;
        logic                      is_full;
    } t_rsp_item;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch incoming request
        logic exec;      // update pointers, count, store
        logic read;      // read front and back entries
        logic load_out;  // load response register
    } t_cmd;

endpackage

// ===== sv/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Request sequencer: capture, execute, read, respond.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output cdq_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_LOAD = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== sv/cdq_dp.sv =====
// ----------------------------------------------------------------------------
// cdq_dp
// Deque datapath: pointers, count, word store and response register.
// ----------------------------------------------------------------------------
module cdq_dp #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdq_pkg::t_cmd      i_cmd,
    input  cdq_pkg::t_req_item i_req,
    output cdq_pkg::t_rsp_item o_rsp
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic signed [cdq_pkg::WORD_W-1:0] r_mem [DEPTH];

    cdq_pkg::t_req_item r_req;
    cdq_pkg::t_status   r_status, n_status;
    logic [PTR_W-1:0]   r_front, n_front;
    logic [PTR_W-1:0]   r_back, n_back;
    logic [CNT_W-1:0]   r_count, n_count;
    logic signed [cdq_pkg::WORD_W-1:0] r_rd_front, r_rd_back;
    cdq_pkg::t_rsp_item r_rsp;

    logic             w_we;
    logic [PTR_W-1:0] w_waddr;
    logic             w_empty, w_full;
    logic [PTR_W-1:0] w_front_inc, w_front_dec, w_back_inc, w_back_dec;

    assign w_empty = (r_count == '0);
    assign w_full  = (r_count == CNT_FULL);

    assign w_front_inc = (r_front == PTR_LAST) ? '0 : r_front + 1'b1;
    assign w_front_dec = (r_front == '0) ? PTR_LAST : r_front - 1'b1;
    assign w_back_inc  = (r_back == PTR_LAST) ? '0 : r_back + 1'b1;
    assign w_back_dec  = (r_back == '0) ? PTR_LAST : r_back - 1'b1;

    always_comb begin
        n_status = cdq_pkg::ST_DONE;
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        w_we     = 1'b0;
        w_waddr  = '0;
        case (r_req.req_type)
            cdq_pkg::REQ_PUSH_FRONT, cdq_pkg::REQ_PUSH_BACK: begin
                if (w_full) begin
                    n_status = cdq_pkg::ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    if (w_empty) begin
                        n_front = '0;
                        n_back  = '0;
                        w_waddr = '0;
                    end else if (r_req.req_type == cdq_pkg::REQ_PUSH_FRONT) begin
                        n_front = w_front_dec;
                        w_waddr = w_front_dec;
                    end else begin
                        n_back  = w_back_inc;
                        w_waddr = w_back_inc;
                    end
                end
            end
            cdq_pkg::REQ_DROP_FRONT, cdq_pkg::REQ_DROP_BACK: begin
                if (w_empty) begin
                    n_status = cdq_pkg::ST_EMPTY;
                end else if (r_count == CNT_W'(1)) begin
                    // last word leaves: pointers go home
                    n_front = '0;
                    n_back  = '0;
                    n_count = '0;
                end else begin
                    n_count = r_count - 1'b1;
                    if (r_req.req_type == cdq_pkg::REQ_DROP_FRONT) begin
                        n_front = w_front_inc;
                    end else begin
                        n_back = w_back_dec;
                    end
                end
            end
            default: n_status = cdq_pkg::ST_DONE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
    end

    // word store: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_waddr] <= r_req.data_in;
        end
        if (i_cmd.read) begin
            r_rd_front <= r_mem[r_front];
            r_rd_back  <= r_mem[r_back];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_rsp.status     <= r_status;
            r_rsp.front_word <= w_empty ? cdq_pkg::EMPTY_WORD : r_rd_front;
            r_rsp.back_word  <= w_empty ? cdq_pkg::EMPTY_WORD : r_rd_back;
            r_rsp.occupancy  <= cdq_pkg::OCC_W'(r_count);
            r_rsp.is_empty   <= w_empty;
            r_rsp.is_full    <= w_full;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== sv/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed 32-bit words in a circular store.
// ----------------------------------------------------------------------------
// Each request pushes a word at the front or back, or drops the front or back
// word; a push into a full queue or a drop from an empty one is rejected
// (status full / empty) and leaves the queue untouched. Each request yields
// one response with the status, the front and back words after the step (all
// ones when empty), the count, and empty / full flags. A request passes four
// steps: capture at the accepting edge, update of pointers, count and store,
// a registered read of the front and back entries, and the response load.
// The response is registered at the end of these steps, and a new request is
// taken only after the previous one has loaded its response. The read of the
// store follows its write as a step of its own. One request is in flight at a
// time; the response register lets the next request be accepted while the
// previous response still waits downstream.
// The store has no reset; only entries that were written are ever shown.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cdq_pkg::t_req_item i_in_req,
    // response channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cdq_pkg::t_rsp_item o_out_rsp
);

    cdq_pkg::t_cmd w_cmd;

    // sequencer: owns both handshakes
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    // pointers, count, store, response register
    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_req   (i_in_req),
        .o_rsp   (o_out_rsp)
    );

endmodule

// ===== sv/cdq_checker.sv =====
// ----------------------------------------------------------------------------
// cdq_checker
// Port-level checks for the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
`include "circular_deque_assert.svh"

module cdq_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input cdq_pkg::t_req_item i_in_req,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cdq_pkg::t_rsp_item o_out_rsp
);

    // held response stays put
    `CDQ_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_rsp))

    // stalled request stays put
    `CDQ_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_in_valid && o_in_stall, i_in_valid && $stable(i_in_req))

    // one request at a time: acceptance closes the input
    `CDQ_ASSERT_NEXT(a_in_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // rejected push only when full
    `CDQ_ASSERT_NOW(a_full_status, i_clk, i_rst_n, o_out_valid && o_out_rsp.status == cdq_pkg::ST_FULL, o_out_rsp.is_full && !o_out_rsp.is_empty)

    // empty queue shows all-ones words and zero count
    `CDQ_ASSERT_NOW(a_empty_words, i_clk, i_rst_n, o_out_valid && o_out_rsp.is_empty, o_out_rsp.front_word == cdq_pkg::EMPTY_WORD && o_out_rsp.back_word == cdq_pkg::EMPTY_WORD && o_out_rsp.occupancy == '0)

endmodule

bind circular_deque cdq_checker u_cdq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_req    (i_in_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_rsp   (o_out_rsp)
);

// ===== test/circular_deque_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking bench for the circular deque.
// ----------------------------------------------------------------------------
// A short table of hand-picked requests walks the queue through its corners:
// drops from an empty queue, a single push and drop, the word extremes, and a
// fill up to the full mark followed by rejected pushes. Random requests
// follow, with the push/drop mix shifting so the count sweeps between empty
// and full. Every response is compared field by field with its table entry
// or a local deque model. Sender gaps and receiver stalls vary per phase; one
// phase holds the receiver off long enough to back the block up, and the
// sender pauses until all responses are in.
// ----------------------------------------------------------------------------
module circular_deque_tb;

    localparam int DEPTH       = cdq_pkg::DEPTH_DEF;
    localparam int HALF_PERIOD = 6;
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int PHASE_ITEMS = 175;   // random requests per idling phase
    localparam int PRESS_ITEMS = 40;    // requests offered during the hold-off
    localparam int TAIL_CYCLES = 20;    // settle time after the last response

    // One row of the directed table. A row with reps > 1 repeats the request
    // with the data word XORed by the repeat index. typed rows carry their
    // expected response; the rest are left to the model.
    typedef struct packed {
        cdq_pkg::t_req_type   kind;
        logic [31:0]          data;
        int                   reps;
        bit                   typed;
        cdq_pkg::t_rsp_item   rsp;
    } t_dir_row;

    localparam cdq_pkg::t_rsp_item RSP_EMPTY_REJ =
        '{cdq_pkg::ST_EMPTY, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 5'd0, 1'b1, 1'b0};
    localparam cdq_pkg::t_rsp_item RSP_NOW_EMPTY =
        '{cdq_pkg::ST_DONE, cdq_pkg::EMPTY_WORD, cdq_pkg::EMPTY_WORD, 5'd0, 1'b1, 1'b0};

    localparam int N_DIR = 12;
    localparam t_dir_row DIR_TAB [N_DIR] = '{
        // drops from an empty queue are rejected
        '{cdq_pkg::REQ_DROP_FRONT, 32'h0000_0000, 1, 1'b1, RSP_EMPTY_REJ},
        '{cdq_pkg::REQ_DROP_BACK,  32'hFFFF_FFFF, 1, 1'b1, RSP_EMPTY_REJ},
        // single word in, then out again: pointers return to zero
        '{cdq_pkg::REQ_PUSH_FRONT, 32'h7FFF_FFFF, 1, 1'b1,
          '{cdq_pkg::ST_DONE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd1, 1'b0, 1'b0}},
        '{cdq_pkg::REQ_DROP_BACK,  32'h1234_5678, 1, 1'b1, RSP_NOW_EMPTY},
        '{cdq_pkg::REQ_PUSH_BACK,  32'h8000_0000, 1, 1'b1,
          '{cdq_pkg::ST_DONE, 32'h8000_0000, 32'h8000_0000, 5'd1, 1'b0, 1'b0}},
        // front pointer steps below entry 0 and wraps
        '{cdq_pkg::REQ_PUSH_FRONT, 32'hFFFF_FFFF, 1, 1'b0, '0},
        '{cdq_pkg::REQ_PUSH_BACK,  32'h0000_0000, 1, 1'b0, '0},
        // fill to DEPTH words from both ends
        '{cdq_pkg::REQ_PUSH_FRONT, 32'h5555_5555, 7, 1'b0, '0},
        '{cdq_pkg::REQ_PUSH_BACK,  32'hAAAA_AAAA, 6, 1'b0, '0},
        // full: both pushes rejected
        '{cdq_pkg::REQ_PUSH_FRONT, 32'h0F0F_0F0F, 1, 1'b0, '0},
        '{cdq_pkg::REQ_PUSH_BACK,  32'hF0F0_F0F0, 1, 1'b0, '0},
        // and room again
        '{cdq_pkg::REQ_DROP_FRONT, 32'h3C3C_3C3C, 1, 1'b0, '0}
    };

    // Idle percentages per random phase: none, sender, receiver, both.
    localparam int N_PHASE = 4;
    localparam int TX_IDLE [N_PHASE] = '{0, 59, 0, 26};
    localparam int RX_IDLE [N_PHASE] = '{0, 0, 59, 26};

    // ------------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------------
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    cdq_pkg::t_req_item i_in_req    = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    cdq_pkg::t_rsp_item o_out_rsp;

    circular_deque #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Deque model: its own store, pointers and count
    // ------------------------------------------------------------------------
    logic signed [cdq_pkg::WORD_W-1:0] dq_words [DEPTH];
    int dq_front = 0;
    int dq_back  = 0;
    int dq_count = 0;

    // Responses still owed by the block, oldest first.
    cdq_pkg::t_rsp_item rsp_expect_q [$];

    int fail_cnt = 0;

    // Applies one request to the model and returns the response it implies.
    function automatic cdq_pkg::t_rsp_item deque_step(input cdq_pkg::t_req_item r);
        cdq_pkg::t_rsp_item rsp;
        rsp.status = cdq_pkg::ST_DONE;
        if (r.req_type == cdq_pkg::REQ_PUSH_FRONT ||
            r.req_type == cdq_pkg::REQ_PUSH_BACK) begin
            if (dq_count == DEPTH) begin
                rsp.status = cdq_pkg::ST_FULL;
            end else begin
                if (dq_count == 0) begin
                    // first word always lands in entry 0
                    dq_front    = 0;
                    dq_back     = 0;
                    dq_words[0] = r.data_in;
                end else if (r.req_type == cdq_pkg::REQ_PUSH_FRONT) begin
                    dq_front           = (dq_front == 0) ? DEPTH - 1 : dq_front - 1;
                    dq_words[dq_front] = r.data_in;
                end else begin
                    dq_back           = (dq_back == DEPTH - 1) ? 0 : dq_back + 1;
                    dq_words[dq_back] = r.data_in;
                end
                dq_count++;
            end
        end else begin
            if (dq_count == 0) begin
                rsp.status = cdq_pkg::ST_EMPTY;
            end else if (dq_count == 1) begin
                // last word gone: back to the reset pointers
                dq_front = 0;
                dq_back  = 0;
                dq_count = 0;
            end else begin
                if (r.req_type == cdq_pkg::REQ_DROP_FRONT)
                    dq_front = (dq_front == DEPTH - 1) ? 0 : dq_front + 1;
                else
                    dq_back = (dq_back == 0) ? DEPTH - 1 : dq_back - 1;
                dq_count--;
            end
        end
        rsp.is_empty   = (dq_count == 0);
        rsp.is_full    = (dq_count == DEPTH);
        rsp.front_word = rsp.is_empty ? cdq_pkg::EMPTY_WORD : dq_words[dq_front];
        rsp.back_word  = rsp.is_empty ? cdq_pkg::EMPTY_WORD : dq_words[dq_back];
        rsp.occupancy  = cdq_pkg::OCC_W'(dq_count);
        return rsp;
    endfunction

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    int tx_pct = 0;   // sender idle percentage, main process only

    // Offers one request after a random gap and returns at the edge where it
    // is taken; the owed response is queued at that edge. Valid is only ever
    // assigned once per edge, so back-to-back requests keep it high.
    task automatic send_req(input cdq_pkg::t_req_item r, input bit typed,
                            input cdq_pkg::t_rsp_item rsp_typed);
        cdq_pkg::t_rsp_item predicted;
        while ($urandom_range(99) < tx_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req   <= r;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = deque_step(r);
        rsp_expect_q.push_back(typed ? rsp_typed : predicted);
    endtask

    // Sender goes quiet until every owed response is in.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (rsp_expect_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Random request; push_pct sets the push/drop mix so the count drifts
    // toward full or toward empty. Data leans on the extremes now and then.
    function automatic cdq_pkg::t_req_item rand_req(input int push_pct);
        cdq_pkg::t_req_item r;
        if ($urandom_range(99) < push_pct)
            r.req_type = $urandom_range(1) ? cdq_pkg::REQ_PUSH_BACK
                                           : cdq_pkg::REQ_PUSH_FRONT;
        else
            r.req_type = $urandom_range(1) ? cdq_pkg::REQ_DROP_BACK
                                           : cdq_pkg::REQ_DROP_FRONT;
        case ($urandom_range(7))
            0:       r.data_in = 32'h7FFF_FFFF;
            1:       r.data_in = 32'h8000_0000;
            2:       r.data_in = 32'hFFFF_FFFF;
            3:       r.data_in = 32'h0000_0000;
            default: r.data_in = $urandom;
        endcase
        return r;
    endfunction

    function automatic int pick_push_pct();
        case ($urandom_range(2))
            0:       return 15;
            1:       return 50;
            default: return 85;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Response side: random stall, plus a long hold-off on request
    // ------------------------------------------------------------------------
    int rx_pct     = 0;   // written by main with NBAs
    int hold_asked = 0;   // bumped by main with NBAs
    int hold_given = 0;
    int hold_left  = 0;

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_asked != hold_given) begin
            hold_given  <= hold_given + 1;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    // Compare each accepted response with the oldest owed one.
    cdq_pkg::t_rsp_item rsp_want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (rsp_expect_q.size() == 0) begin
                $error("response with none owed: %p", o_out_rsp);
                fail_cnt++;
            end else begin
                rsp_want = rsp_expect_q.pop_front();
                if (o_out_rsp.status !== rsp_want.status) begin
                    $error("status: expected %0d, got %0d",
                           rsp_want.status, o_out_rsp.status);
                    fail_cnt++;
                end
                if (o_out_rsp.front_word !== rsp_want.front_word) begin
                    $error("front_word: expected %0d, got %0d",
                           rsp_want.front_word, o_out_rsp.front_word);
                    fail_cnt++;
                end
                if (o_out_rsp.back_word !== rsp_want.back_word) begin
                    $error("back_word: expected %0d, got %0d",
                           rsp_want.back_word, o_out_rsp.back_word);
                    fail_cnt++;
                end
                if (o_out_rsp.occupancy !== rsp_want.occupancy) begin
                    $error("occupancy: expected %0d, got %0d",
                           rsp_want.occupancy, o_out_rsp.occupancy);
                    fail_cnt++;
                end
                if (o_out_rsp.is_empty !== rsp_want.is_empty) begin
                    $error("is_empty: expected %0b, got %0b",
                           rsp_want.is_empty, o_out_rsp.is_empty);
                    fail_cnt++;
                end
                if (o_out_rsp.is_full !== rsp_want.is_full) begin
                    $error("is_full: expected %0b, got %0b",
                           rsp_want.is_full, o_out_rsp.is_full);
                    fail_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        cdq_pkg::t_req_item req;
        int                 push_pct;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners, no idling
        foreach (DIR_TAB[i]) begin
            for (int k = 0; k < DIR_TAB[i].reps; k++) begin
                req.req_type = DIR_TAB[i].kind;
                req.data_in  = DIR_TAB[i].data ^ 32'(k);
                send_req(req, DIR_TAB[i].typed, DIR_TAB[i].rsp);
            end
        end

        // random phases with shifting idle patterns
        for (int p = 0; p < N_PHASE; p++) begin
            tx_pct  = TX_IDLE[p];
            rx_pct <= RX_IDLE[p];
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 25 == 0)
                    push_pct = pick_push_pct();
                send_req(rand_req(push_pct), 1'b0, '0);
            end

            if (p == 0) begin
                // receiver held off while the sender keeps pushing requests;
                // the block backs up and stalls its input
                rx_pct     <= 0;
                hold_asked <= hold_asked + 1;
                for (int n = 0; n < PRESS_ITEMS; n++)
                    send_req(rand_req(50), 1'b0, '0);
                // sender pauses until everything is back
                wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        if (fail_cnt == 0 && rsp_expect_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Hard stop, far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
